>>> hdl/udp_rcp_pkg.sv
// shared types and constants for the udp receive check and parse block
`default_nettype none
package udp_rcp_pkg;

  localparam int unsigned CNT_W   = 17;
  localparam int unsigned PSEUDO_W = 18;
  localparam int unsigned EXTRA_W = 19;

  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [15:0]      WORD_ONES = 16'hFFFF;
  localparam logic [15:0]      HDR_BYTES = 16'd8;
  localparam logic [7:0]       UDP_PROTO = 8'd17;

  // header byte offsets
  localparam logic [CNT_W-1:0] OFS_SRC_HI = 17'd0;
  localparam logic [CNT_W-1:0] OFS_SRC_LO = 17'd1;
  localparam logic [CNT_W-1:0] OFS_DST_HI = 17'd2;
  localparam logic [CNT_W-1:0] OFS_DST_LO = 17'd3;
  localparam logic [CNT_W-1:0] OFS_LEN_HI = 17'd4;
  localparam logic [CNT_W-1:0] OFS_LEN_LO = 17'd5;
  localparam logic [CNT_W-1:0] OFS_CSM_HI = 17'd6;
  localparam logic [CNT_W-1:0] OFS_CSM_LO = 17'd7;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SHORT   = 2'd1,
    ST_BAD_LEN = 2'd2,
    ST_BAD_SUM = 2'd3
  } status_e;

  // per-datagram summary handed from the accumulator to the verdict stages
  typedef struct packed {
    logic                 short_hdr;
    logic                 bad_len;
    logic                 csm_zero;
    logic [15:0]          src_port;
    logic [15:0]          dst_port;
    logic [15:0]          pay_len;
    logic [31:0]          run_sum;
    logic [EXTRA_W-1:0]   extra_sum;
  } prep_t;

endpackage
`default_nettype wire

>>> hdl/udp_rcp_accum.sv
// per-byte header capture, byte count and running sum, with a summary register
`default_nettype none
module udp_rcp_accum (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              en_i,
  input  wire logic                              valid_i,
  input  wire logic [7:0]                        data_i,
  input  wire logic                              first_i,
  input  wire logic                              last_i,
  input  wire logic [udp_rcp_pkg::PSEUDO_W-1:0]  pseudo_i,
  output logic                                   prep_valid_o,
  output udp_rcp_pkg::prep_t                     prep_o
);
  import udp_rcp_pkg::*;

  logic [CNT_W-1:0]    cnt_q, cnt_d, cnt_base;
  logic [31:0]         sum_q, sum_d, sum_base, addend;
  logic [15:0]         len_q, len_d, len_base;
  logic                csz_q, csz_d, csz_base;
  logic [15:0]         sp_q, sp_d, sp_base;
  logic [15:0]         dp_q, dp_d, dp_base;
  logic [PSEUDO_W-1:0] pas_q, pas_d;
  logic                take;
  prep_t               prep_d, prep_q;
  logic                prep_valid_q;

  assign take = en_i & valid_i;

  always_comb begin
    // a first byte restarts the datagram
    cnt_base = first_i ? '0 : cnt_q;
    sum_base = first_i ? '0 : sum_q;
    len_base = first_i ? '0 : len_q;
    csz_base = first_i ? 1'b1 : csz_q;
    sp_base  = first_i ? '0 : sp_q;
    dp_base  = first_i ? '0 : dp_q;
    pas_d    = first_i ? pseudo_i : pas_q;

    len_d = len_base;
    csz_d = csz_base;
    sp_d  = sp_base;
    dp_d  = dp_base;
    case (cnt_base)
      OFS_SRC_HI: sp_d  = {data_i, sp_base[7:0]};
      OFS_SRC_LO: sp_d  = {sp_base[15:8], data_i};
      OFS_DST_HI: dp_d  = {data_i, dp_base[7:0]};
      OFS_DST_LO: dp_d  = {dp_base[15:8], data_i};
      OFS_LEN_HI: len_d = {data_i, len_base[7:0]};
      OFS_LEN_LO: len_d = {len_base[15:8], data_i};
      OFS_CSM_HI: csz_d = (data_i == 8'd0);
      OFS_CSM_LO: csz_d = csz_base & (data_i == 8'd0);
      default: ;
    endcase

    // odd offsets are the low byte of a big-endian word
    addend = cnt_base[0] ? {24'd0, data_i} : {16'd0, data_i, 8'd0};
    if ((cnt_base < OFS_CSM_HI) || (cnt_base < {1'b0, len_d})) begin
      sum_d = sum_base + addend;
    end else begin
      sum_d = sum_base;
    end

    cnt_d = (cnt_base == CNT_MAX) ? cnt_base : cnt_base + 1'b1;

    prep_d.short_hdr = cnt_d < {1'b0, HDR_BYTES};
    prep_d.bad_len   = (len_d < HDR_BYTES) || ({1'b0, len_d} > cnt_d);
    prep_d.csm_zero  = csz_d;
    prep_d.src_port  = sp_d;
    prep_d.dst_port  = dp_d;
    prep_d.pay_len   = len_d - HDR_BYTES;
    prep_d.run_sum   = sum_d;
    prep_d.extra_sum = {1'b0, pas_d} + {11'd0, UDP_PROTO} + {3'd0, len_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      sum_q        <= '0;
      len_q        <= '0;
      csz_q        <= 1'b1;
      sp_q         <= '0;
      dp_q         <= '0;
      pas_q        <= '0;
      prep_valid_q <= 1'b0;
    end else begin
      if (take) begin
        cnt_q <= cnt_d;
        sum_q <= sum_d;
        len_q <= len_d;
        csz_q <= csz_d;
        sp_q  <= sp_d;
        dp_q  <= dp_d;
        pas_q <= pas_d;
      end
      if (en_i) begin
        prep_valid_q <= valid_i & last_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      prep_q <= prep_d;
    end
  end

  assign prep_valid_o = prep_valid_q;
  assign prep_o       = prep_q;

endmodule
`default_nettype wire

>>> hdl/udp_rcp_verdict.sv
// final checksum add, fold and status decision, ending in the result register
`default_nettype none
module udp_rcp_verdict (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                prep_valid_i,
  input  wire udp_rcp_pkg::prep_t  prep_i,
  output logic                     out_valid_o,
  output udp_rcp_pkg::status_e     status_o,
  output logic [15:0]              src_port_o,
  output logic [15:0]              dst_port_o,
  output logic [15:0]              pay_len_o
);
  import udp_rcp_pkg::*;

  logic        tot_valid_q;
  logic [31:0] tot_q;
  logic        short_q, bad_len_q, csz_q;
  logic [15:0] sp_q, dp_q, pl_q;
  logic [16:0] fold1;
  logic [15:0] fold2;
  logic        sum_ok;
  status_e     status_d, status_q;
  logic [15:0] pl_d;
  logic        out_valid_q;
  logic [15:0] src_q, dst_q, pay_q;

  always_comb begin
    fold1  = {1'b0, tot_q[15:0]} + {1'b0, tot_q[31:16]};
    fold2  = fold1[15:0] + {15'd0, fold1[16]};
    sum_ok = (fold2 == WORD_ONES);
    pl_d   = '0;
    if (short_q) begin
      status_d = ST_SHORT;
    end else if (bad_len_q) begin
      status_d = ST_BAD_LEN;
    end else if (!csz_q && !sum_ok) begin
      status_d = ST_BAD_SUM;
    end else begin
      status_d = ST_OK;
      pl_d     = pl_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      tot_valid_q <= prep_valid_i;
      out_valid_q <= tot_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && prep_valid_i) begin
      tot_q     <= prep_i.run_sum + {13'd0, prep_i.extra_sum};
      short_q   <= prep_i.short_hdr;
      bad_len_q <= prep_i.bad_len;
      csz_q     <= prep_i.csm_zero;
      sp_q      <= prep_i.src_port;
      dp_q      <= prep_i.dst_port;
      pl_q      <= prep_i.pay_len;
    end
    if (en_i && tot_valid_q) begin
      status_q <= status_d;
      src_q    <= sp_q;
      dst_q    <= dp_q;
      pay_q    <= pl_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign src_port_o  = src_q;
  assign dst_port_o  = dst_q;
  assign pay_len_o   = pay_q;

endmodule
`default_nettype wire

>>> hdl/udp_receive_check_parse.sv
// top level of the udp receive check and parse block
`default_nettype none
// Takes a received UDP datagram one byte per item, header first, with first
// and last marks; the IPv4 addresses are sampled with the first byte. Exactly
// one result item comes out for every item that carries last_byte: status
// (ok, shorter than header, bad length, bad checksum), both ports and the
// payload length. A new byte is accepted in every cycle in which in_ready_o
// is high; a result is presented once its last byte has passed the
// accumulator, checksum add, and fold and verdict stages, each ending in a
// register behind the input register. The whole pipeline advances together,
// so in_ready_o drops only while a finished result sits unread in the output
// register and out_ready_i is low. No clearing pass is needed after reset.
module udp_receive_check_parse (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        first_byte_i,
  input  wire logic        last_byte_i,
  input  wire logic [31:0] source_address_i,
  input  wire logic [31:0] destination_address_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [15:0]      source_port_o,
  output logic [15:0]      destination_port_o,
  output logic [15:0]      payload_length_o
);
  import udp_rcp_pkg::*;

  // global pipeline advance: move when the result register is free or drains
  logic                en;

  // input register
  logic                in_valid_q;
  logic [7:0]          data_q;
  logic                first_q;
  logic                last_q;
  logic [PSEUDO_W-1:0] pseudo_q;
  logic [PSEUDO_W-1:0] pseudo_d;

  logic                prep_valid;
  prep_t               prep;
  status_e             status;

  assign en         = ~out_valid_o | out_ready_i;
  assign in_ready_o = en;

  // address half of the pseudo-header, four 16-bit words
  assign pseudo_d = {2'd0, source_address_i[31:16]}
                  + {2'd0, source_address_i[15:0]}
                  + {2'd0, destination_address_i[31:16]}
                  + {2'd0, destination_address_i[15:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (en) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      data_q   <= data_byte_i;
      first_q  <= first_byte_i;
      last_q   <= last_byte_i;
      pseudo_q <= pseudo_d;
    end
  end

  // byte count, header fields and running sum
  udp_rcp_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (in_valid_q),
    .data_i       (data_q),
    .first_i      (first_q),
    .last_i       (last_q),
    .pseudo_i     (pseudo_q),
    .prep_valid_o (prep_valid),
    .prep_o       (prep)
  );

  // final add, one's-complement fold and status
  udp_rcp_verdict u_verdict (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .prep_valid_i (prep_valid),
    .prep_i       (prep),
    .out_valid_o  (out_valid_o),
    .status_o     (status),
    .src_port_o   (source_port_o),
    .dst_port_o   (destination_port_o),
    .pay_len_o    (payload_length_o)
  );

  assign status_o = status;

endmodule
`default_nettype wire
